/* hdl/epmd_pkg.sv */
// Shared types and constants for the encoder PID motor drive.
// No dependencies; every other file in hdl/ imports this package.
package epmd_pkg;

  // Width of the encoder position counter (range 16..64).
  localparam int COUNT_WIDTH = 32;
  // Count difference is limited to +-2^22 before the speed map; the map
  // saturates long before that, so the result is unchanged.
  localparam int DLT_W = 24;
  localparam int DXW   = (COUNT_WIDTH > DLT_W) ? COUNT_WIDTH : DLT_W;

  // Shared multiplier and divider sizes.
  localparam int MA_W  = 33;
  localparam int MB_W  = 17;
  localparam int PR_W  = MA_W + MB_W;
  localparam int NUM_W = 34;
  localparam int DEN_W = 13;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_KP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DB   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DFS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_EFS  = 3'd7;

  // Stream widths.
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  // The target map divides by 200: the product is shifted right by three,
  // then multiplied by ceil(2^24 / 25) and shifted right by 24. This is exact
  // for every 19-bit operand.
  localparam logic [19:0] TGT_RECIP = 20'd671089;
  localparam int          TGT_SHIFT = 24;

  typedef enum logic [1:0] {
    OP_EDGE    = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_CONTROL = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              enc_b;
    logic signed [9:0] target;
    logic              clr;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S_SET,
    ST_S_MUL,
    ST_S_DIV,
    ST_S_WAIT,
    ST_C_SET,
    ST_C_TMUL,
    ST_C_TDIV,
    ST_C_TWAIT,
    ST_C_TERR,
    ST_C_LMUL,
    ST_C_LEAK,
    ST_C_PMUL,
    ST_C_PROP,
    ST_C_DMUL,
    ST_C_DER,
    ST_C_IMUL,
    ST_C_INT,
    ST_C_RSET,
    ST_C_RMUL,
    ST_C_RDIV,
    ST_C_RWAIT,
    ST_C_OUT
  } back_state_e;

endpackage

/* hdl/epmd_front.sv */
// Front end: accepts input words, drops unused op codes and queues the rest.
// Depends on epmd_pkg.
module epmd_front import epmd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,  // encoder_b, target_percent, clear_integral
  input  logic [IN_USER_W-1:0] s_axis_tuser,  // op
  output item_t                item_o,
  output logic                 item_valid_o,
  input  logic                 item_pop_i
);

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       keep, push, pop;
  item_t      item_in;

  // Classify the incoming word; op code 3 has no effect and is not queued.
  always_comb begin
    item_in.enc_b  = s_axis_tdata[0];
    item_in.target = $signed(s_axis_tdata[10:1]);
    item_in.clr    = s_axis_tdata[11];
    item_in.op     = OP_EDGE;
    keep           = 1'b1;
    unique case (s_axis_tuser)
      OP_EDGE:    item_in.op = OP_EDGE;
      OP_SAMPLE:  item_in.op = OP_SAMPLE;
      OP_CONTROL: item_in.op = OP_CONTROL;
      default:    keep = 1'b0;
    endcase
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid & s_axis_tready & keep;
  assign pop           = item_pop_i & item_valid_o;
  assign item_valid_o  = (cnt_q != 2'd0);
  assign item_o        = slot_q[rd_ptr_q];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

/* hdl/epmd_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on epmd_pkg.
module epmd_div import epmd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d, done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0]  rem_q, rem_d, den_q, den_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DEN_W:0]    shifted;
  logic              fits;

  // One shift and trial subtract a cycle.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    shifted = {rem_q, quo_q[NUM_W-1]};
    fits    = (shifted >= {1'b0, den_q});
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = req_i.den;
      quo_d  = req_i.num;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

/* hdl/epmd_back.sv */
// Back end: encoder count, speed map and PID step on a shared multiplier
// and divider, with the result word register. Depends on epmd_pkg.
module epmd_back import epmd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]  cfg_data_i,
  input  item_t                 item_i,
  input  logic                  item_valid_i,
  output logic                  item_pop_o,
  output div_req_t              div_req_o,
  input  div_rsp_t              div_rsp_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata  // direction, duty, speed_seen, drive_effort
);

  back_state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] kp_q, ki_q, kd_q, leak_q;
  logic [7:0]  db_q, min_q, dfs_q;
  logic [11:0] efs_q;

  // Controller state.
  logic [COUNT_WIDTH-1:0] pos_q, pos_d, last_q, last_d;
  logic signed [10:0]     cur_q, cur_d, prev_q, prev_d;
  logic signed [31:0]     integ_q, integ_d;

  // Working registers.
  item_t                  item_q;
  logic signed [MA_W-1:0] mul_a_q, mul_a_d;
  logic signed [MB_W-1:0] mul_b_q, mul_b_d;
  logic signed [PR_W-1:0] prod_q;
  logic signed [PR_W:0]   sum_q, sum_d;
  logic signed [15:0]     err_q, err_d;
  logic signed [11:0]     acc_q, acc_d;
  logic signed [17:0]     v_q, v_d;
  logic                   neg_q, neg_d;
  logic                   res_dir_q, res_dir_d;
  logic [7:0]             res_duty_q, res_duty_d;
  logic signed [8:0]      res_p_q, res_p_d;
  logic                   m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0]  m_data_q, m_data_d;
  logic [18:0]            tdiv_q;
  logic [14:0]            tquo_q;

  // Full scales, zero acting as one.
  logic [7:0]  dfs;
  logic [11:0] efs;
  assign dfs = (dfs_q == 8'd0) ? 8'd1 : dfs_q;
  assign efs = (efs_q == 12'd0) ? 12'd1 : efs_q;

  // Intermediate values.
  logic [COUNT_WIDTH-1:0] diff;
  logic signed [DXW-1:0]  diffx;
  logic signed [DLT_W-1:0] dlt;
  logic signed [DLT_W:0]   dlt_e;
  logic signed [9:0]      d_s, tc;
  logic signed [10:0]     tplus;
  logic signed [NUM_W:0]  qs, spd;
  logic [38:0]            trec;
  logic signed [15:0]     tsq, tgt;
  logic signed [33:0]     lk_s, itot;
  logic signed [32:0]     imag;
  logic signed [31:0]     integ_clr;
  logic signed [PR_W:0]   vt;
  logic signed [17:0]     vmag, db256;
  logic signed [9:0]      dmm;
  logic signed [PR_W-1:0] aprod;
  logic signed [26:0]     rmag, r, w, wabs;
  logic signed [19:0]     pm, ps, d20;
  logic signed [8:0]      p9;
  logic                   start;
  logic                   out_free;

  assign out_free = ~m_valid_q | m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          unique case (item_i.op)
            OP_SAMPLE:  state_d = ST_S_SET;
            OP_CONTROL: state_d = ST_C_SET;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_S_SET:   state_d = ST_S_MUL;
      ST_S_MUL:   state_d = ST_S_DIV;
      ST_S_DIV:   state_d = ST_S_WAIT;
      ST_S_WAIT:  state_d = div_rsp_i.done ? ST_IDLE : ST_S_WAIT;
      ST_C_SET:   state_d = ST_C_TMUL;
      ST_C_TMUL:  state_d = ST_C_TDIV;
      ST_C_TDIV:  state_d = ST_C_TWAIT;
      ST_C_TWAIT: state_d = ST_C_TERR;
      ST_C_TERR:  state_d = ST_C_LMUL;
      ST_C_LMUL:  state_d = ST_C_LEAK;
      ST_C_LEAK:  state_d = ST_C_PMUL;
      ST_C_PMUL:  state_d = ST_C_PROP;
      ST_C_PROP:  state_d = ST_C_DMUL;
      ST_C_DMUL:  state_d = ST_C_DER;
      ST_C_DER:   state_d = ST_C_IMUL;
      ST_C_IMUL:  state_d = ST_C_INT;
      ST_C_INT:   state_d = ST_C_RSET;
      ST_C_RSET:  state_d = ST_C_RMUL;
      ST_C_RMUL:  state_d = ST_C_RDIV;
      ST_C_RDIV:  state_d = ST_C_RWAIT;
      ST_C_RWAIT: state_d = div_rsp_i.done ? ST_C_OUT : ST_C_RWAIT;
      ST_C_OUT:   state_d = out_free ? ST_IDLE : ST_C_OUT;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Arithmetic shared by several steps.
  always_comb begin
    // Count difference since the last sample, limited.
    diff  = pos_q - last_q;
    diffx = DXW'($signed(diff));
    if (diffx > $signed(DXW'(2 ** 22))) begin
      dlt = DLT_W'(2 ** 22);
    end else if (diffx < $signed(-DXW'(2 ** 22))) begin
      dlt = -DLT_W'(2 ** 22);
    end else begin
      dlt = diffx[DLT_W-1:0];
    end
    dlt_e = (DLT_W + 1)'(dlt) + $signed({13'd0, efs});

    // Target percent clamped to the duty full scale.
    d_s = $signed({2'b00, dfs});
    if (item_q.target > d_s) begin
      tc = d_s;
    end else if (item_q.target < -d_s) begin
      tc = -d_s;
    end else begin
      tc = item_q.target;
    end
    tplus = 11'(tc) + 11'sd100;

    // Signed quotient of the last division.
    qs  = neg_q ? -$signed({1'b0, div_rsp_i.quo}) : $signed({1'b0, div_rsp_i.quo});
    spd = qs - $signed((NUM_W + 1)'(dfs));

    // Target quotient by 200 through the reciprocal of 25.
    trec = tdiv_q * TGT_RECIP;
    tsq  = neg_q ? -$signed({1'b0, tquo_q}) : $signed({1'b0, tquo_q});
    tgt  = tsq - $signed({4'd0, efs});

    // Leaky integrator.
    integ_clr = item_q.clr ? 32'sd0 : integ_q;
    imag      = integ_clr[31] ? -33'(integ_clr) : 33'(integ_clr);
    lk_s      = integ_q[31] ? -$signed({2'b00, prod_q[47:16]})
                            : $signed({2'b00, prod_q[47:16]});
    itot      = lk_s + 34'(err_q);

    // Drive sum and deadzone remap.
    vt    = sum_q + (PR_W + 1)'(prod_q);
    vmag  = v_q[17] ? -v_q : v_q;
    db256 = $signed({2'b00, db_q, 8'h00});
    dmm   = $signed({2'b00, dfs}) - $signed({2'b00, min_q});
    aprod = prod_q[PR_W-1] ? -prod_q : prod_q;
    rmag  = $signed({11'd0, min_q, 8'h00}) + 27'(qs);
    if (v_q > db256) begin
      r = rmag;
    end else if (v_q < -db256) begin
      r = -rmag;
    end else begin
      r = 27'sd0;
    end

    // Round after +0.5 toward zero, then limit to the full scale.
    w    = r + 27'sd128;
    wabs = w[26] ? -w : w;
    pm   = 20'(wabs[26:8]);
    ps   = w[26] ? -pm : pm;
    d20  = $signed({12'd0, dfs});
    if (ps > d20) begin
      p9 = 9'(d20);
    end else if (ps < -d20) begin
      p9 = 9'(-d20);
    end else begin
      p9 = 9'(ps);
    end
  end

  // Datapath updates per step.
  always_comb begin
    pos_d      = pos_q;
    last_d     = last_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    integ_d    = integ_q;
    mul_a_d    = mul_a_q;
    mul_b_d    = mul_b_q;
    sum_d      = sum_q;
    err_d      = err_q;
    acc_d      = acc_q;
    v_d        = v_q;
    neg_d      = neg_q;
    res_dir_d  = res_dir_q;
    res_duty_d = res_duty_q;
    res_p_d    = res_p_q;
    item_pop_o = 1'b0;
    start      = 1'b0;
    div_req_o.num = aprod[NUM_W-1:0];
    div_req_o.den = DEN_W'(dfs);
    m_valid_d  = m_valid_q & ~m_axis_tready;
    m_data_d   = m_data_q;

    unique case (state_q)
      ST_IDLE: begin
        item_pop_o = item_valid_i;
        if (item_valid_i && item_i.op == OP_EDGE) begin
          pos_d = item_i.enc_b ? pos_q - 1'b1 : pos_q + 1'b1;
        end
      end
      ST_S_SET: begin
        mul_a_d = MA_W'(dlt_e);
        mul_b_d = $signed({8'd0, dfs, 1'b0});
      end
      ST_S_DIV: begin
        start         = 1'b1;
        neg_d         = prod_q[PR_W-1];
        div_req_o.den = {efs, 1'b0};
      end
      ST_S_WAIT: begin
        if (div_rsp_i.done) begin
          if (spd > (NUM_W + 1)'(1023)) begin
            cur_d = 11'sd1023;
          end else if (spd < -(NUM_W + 1)'(1023)) begin
            cur_d = -11'sd1023;
          end else begin
            cur_d = 11'(spd);
          end
          last_d = pos_q;
        end
      end
      ST_C_SET: begin
        mul_a_d = MA_W'(tplus);
        mul_b_d = $signed({4'd0, efs, 1'b0});
      end
      ST_C_TDIV: begin
        neg_d = prod_q[PR_W-1];
      end
      ST_C_TERR: begin
        err_d   = tgt - 16'(cur_q);
        acc_d   = 12'(cur_q) - 12'(prev_q);
        prev_d  = cur_q;
        integ_d = integ_clr;
        mul_a_d = imag;
        mul_b_d = $signed({1'b0, leak_q});
      end
      ST_C_LEAK: begin
        if (itot > 34'sh0_7FFF_FFFF) begin
          integ_d = 32'sh7FFF_FFFF;
        end else if (itot < -34'sh0_8000_0000) begin
          integ_d = -32'sh8000_0000;
        end else begin
          integ_d = 32'(itot);
        end
        mul_a_d = MA_W'(err_q);
        mul_b_d = $signed({1'b0, kp_q});
      end
      ST_C_PROP: begin
        sum_d   = (PR_W + 1)'(prod_q);
        mul_a_d = MA_W'(acc_q);
        mul_b_d = $signed({1'b0, kd_q});
      end
      ST_C_DER: begin
        sum_d   = vt;
        mul_a_d = MA_W'(integ_q);
        mul_b_d = $signed({1'b0, ki_q});
      end
      ST_C_INT: begin
        if (vt >= (PR_W + 1)'(65536)) begin
          v_d = 18'sd65280;
        end else if (vt <= -(PR_W + 1)'(65536)) begin
          v_d = -18'sd65280;
        end else begin
          v_d = 18'(vt);
        end
      end
      ST_C_RSET: begin
        mul_a_d = MA_W'(vmag);
        mul_b_d = MB_W'(dmm);
      end
      ST_C_RDIV: begin
        start = 1'b1;
        neg_d = prod_q[PR_W-1];
      end
      ST_C_RWAIT: begin
        if (div_rsp_i.done) begin
          res_p_d    = p9;
          res_dir_d  = ~p9[8];
          res_duty_d = p9[8] ? 8'(-p9) : dfs - p9[7:0];
        end
      end
      ST_C_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {3'd0, res_p_q, cur_q, res_duty_q, res_dir_q};
        end
      end
      default: ;
    endcase
    div_req_o.start = start;
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      pos_q     <= '0;
      last_q    <= '0;
      cur_q     <= '0;
      prev_q    <= '0;
      integ_q   <= '0;
      kp_q      <= 16'd256;
      ki_q      <= 16'd0;
      kd_q      <= 16'd0;
      leak_q    <= 16'd62259;
      db_q      <= 8'd10;
      min_q     <= 8'd60;
      dfs_q     <= 8'd255;
      efs_q     <= 12'd100;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      pos_q     <= pos_d;
      last_q    <= last_d;
      cur_q     <= cur_d;
      prev_q    <= prev_d;
      integ_q   <= integ_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KP:   kp_q   <= cfg_data_i;
          CFG_KI:   ki_q   <= cfg_data_i;
          CFG_KD:   kd_q   <= cfg_data_i;
          CFG_LEAK: leak_q <= cfg_data_i;
          CFG_DB:   db_q   <= cfg_data_i[7:0];
          CFG_MIN:  min_q  <= cfg_data_i[7:0];
          CFG_DFS:  dfs_q  <= cfg_data_i[7:0];
          CFG_EFS:  efs_q  <= cfg_data_i[11:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers; the product registers follow their operands each cycle.
  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      item_q <= item_i;
    end
    mul_a_q    <= mul_a_d;
    mul_b_q    <= mul_b_d;
    prod_q     <= mul_a_q * mul_b_q;
    tdiv_q     <= aprod[21:3];
    tquo_q     <= trec[TGT_SHIFT+14:TGT_SHIFT];
    sum_q      <= sum_d;
    err_q      <= err_d;
    acc_q      <= acc_d;
    v_q        <= v_d;
    neg_q      <= neg_d;
    res_dir_q  <= res_dir_d;
    res_duty_q <= res_duty_d;
    res_p_q    <= res_p_d;
    m_data_q   <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

/* hdl/encoder_pid_motor_drive.sv */
// Top level of the encoder PID motor drive: front queue, back sequencer
// and shared divider. Depends on epmd_pkg, epmd_front, epmd_back, epmd_div.
//
//  Channel | Direction | Contents
//  s_axis  | in        | tuser: op; tdata: encoder_b, target_percent, clear_integral
//  m_axis  | out       | tdata: direction, duty, speed_seen, drive_effort
//  cfg     | in        | cfg_we_i, cfg_idx_i, cfg_data_i; one register per write
//
// An encoder edge is handled in the back end's idle state itself; for a sample or a control
// tick, the shared divider takes most of the time.
// The front queue holds two words, so input is taken while the back end works.
// Reset clears the control and controller state and loads the register defaults; a result word waits
// in its register until taken, stalling only the back end.
module encoder_pid_motor_drive import epmd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [0] encoder_b, [10:1] target_percent, [11] clear_integral
  input  logic [IN_USER_W-1:0]  s_axis_tuser,  // [1:0] op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [0] direction, [8:1] duty, [19:9] speed_seen, [28:20] drive_effort
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]  cfg_data_i
);

  item_t    item;
  logic     item_valid, item_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  epmd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  epmd_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  epmd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

/* dv/tb_encoder_pid_motor_drive.sv */
`timescale 1ns / 1ps
// Self-checking testbench for encoder_pid_motor_drive: encoder, sample and control
// words are streamed in, and each control result is checked against a built-in predictor.
// Depends on epmd_pkg and the RTL under hdl/.
module tb_encoder_pid_motor_drive;
  import epmd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [1:0] op;
    logic       enc_b;
    logic [9:0] target;
    logic       clr;
  } drive_word_t;

  typedef struct {
    logic              dir;
    logic [7:0]        duty;
    logic signed [10:0] speed;
    logic [8:0]        effort;
  } drive_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;  // [0] encoder_b, [10:1] target, [11] clear
  logic [IN_USER_W-1:0] s_axis_tuser = '0;  // [1:0] op
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;      // [0] dir, [8:1] duty, [19:9] speed, [28:20] effort
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  encoder_pid_motor_drive dut (.*);

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  drive_word_t   pending_words[$];
  drive_result_t expected_drive[$];
  int  error_count = 0;
  int  words_sent = 0;
  int  results_checked = 0;
  bit  idling_on = 1'b1;

  // Predictor copy of the registers and state.
  longint kp, ki, kd, leak, dead_band, min_duty, duty_fs, enc_fs;
  logic [31:0] position, last_position;
  longint speed_now, speed_prev, integral;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Advances the predictor by one word; returns 1 when the word yields a result.
  function automatic bit predict_drive(input drive_word_t w, output drive_result_t res);
    longint d, e, delta, t, target, err, accel, mag, lk, v, r, wr, p;
    logic [31:0] diff;
    d = (duty_fs == 0) ? 1 : duty_fs;
    e = (enc_fs == 0) ? 1 : enc_fs;
    res = '{default: '0};
    case (w.op)
      OP_EDGE: begin
        position = w.enc_b ? position - 32'd1 : position + 32'd1;
        return 1'b0;
      end
      OP_SAMPLE: begin
        diff = position - last_position;
        delta = longint'($signed(diff));
        speed_now = clamp((delta + e) * (2 * d) / (2 * e) - d, -1023, 1023);
        last_position = position;
        return 1'b0;
      end
      OP_CONTROL: begin
        t = clamp(longint'($signed(w.target)), -d, d);
        target = (t + 100) * (2 * e) / 200 - e;
        accel = speed_now - speed_prev;
        speed_prev = speed_now;
        err = target - speed_now;
        if (w.clr) integral = 0;
        mag = integral < 0 ? -integral : integral;
        lk = (mag * leak) >>> 16;
        if (integral < 0) lk = -lk;
        integral = clamp(lk + err, -64'sd2147483648, 64'sd2147483647);
        v = kp * err + kd * accel + ki * integral;
        if (v >= 65536) v = 65280;
        if (v <= -65536) v = -65280;
        if (v > dead_band * 256) r = min_duty * 256 + v * (d - min_duty) / d;
        else if (v < -dead_band * 256) r = -(min_duty * 256 + (-v) * (d - min_duty) / d);
        else r = 0;
        wr = r + 128;
        p = wr >= 0 ? (wr >>> 8) : -((-wr) >>> 8);
        p = clamp(p, -d, d);
        res.dir = (p >= 0);
        res.duty = (p >= 0) ? 8'(d - p) : 8'(-p);
        res.speed = 11'(speed_now);
        res.effort = 9'(p);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Sender: feeds queued words, with random idle bursts.
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 9);
        s_axis_tvalid <= 1'b0;
      end else begin
        drive_word_t w;
        w = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= w.op;
        s_axis_tdata <= {4'b0, w.clr, w.target, w.enc_b};
      end
    end
  end

  // Receiver ready, with random stall bursts.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Input monitor: predicts the outcome of every accepted word.
  always @(posedge clk_i) begin
    drive_word_t w;
    drive_result_t res;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      w.op = s_axis_tuser;
      w.enc_b = s_axis_tdata[0];
      w.target = s_axis_tdata[10:1];
      w.clr = s_axis_tdata[11];
      words_sent++;
      if (predict_drive(w, res)) expected_drive.push_back(res);
    end
  end

  // Output monitor: compares each result word with the oldest prediction.
  always @(posedge clk_i) begin
    drive_result_t exp_r, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.dir = m_axis_tdata[0];
      got.duty = m_axis_tdata[8:1];
      got.speed = m_axis_tdata[19:9];
      got.effort = m_axis_tdata[28:20];
      if (expected_drive.size() == 0) begin
        $display("%0t: unexpected result word dir=%0b duty=%0d speed=%0d effort=%0d",
                 $time, got.dir, got.duty, got.speed, $signed(got.effort));
        error_count++;
      end else begin
        exp_r = expected_drive.pop_front();
        results_checked++;
        if (got.dir !== exp_r.dir) begin
          $display("%0t: direction expected %0b actual %0b", $time, exp_r.dir, got.dir);
          error_count++;
        end
        if (got.duty !== exp_r.duty) begin
          $display("%0t: duty expected %0d actual %0d", $time, exp_r.duty, got.duty);
          error_count++;
        end
        if (got.speed !== exp_r.speed) begin
          $display("%0t: speed_seen expected %0d actual %0d", $time, exp_r.speed, got.speed);
          error_count++;
        end
        if (got.effort !== exp_r.effort) begin
          $display("%0t: drive_effort expected %0d actual %0d", $time,
                   $signed(exp_r.effort), $signed(got.effort));
          error_count++;
        end
      end
    end
  end

  task automatic add_word(logic [1:0] op, logic b, logic [9:0] t, logic c);
    drive_word_t w;
    w.op = op;
    w.enc_b = b;
    w.target = t;
    w.clr = c;
    pending_words.push_back(w);
  endtask

  // Waits until every word is taken and every result has arrived, then lets
  // the back end finish any word that yields no result.
  task automatic wait_drained();
    while (pending_words.size() != 0 || s_axis_tvalid || expected_drive.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_KP:   kp = val;
      CFG_KI:   ki = val;
      CFG_KD:   kd = val;
      CFG_LEAK: leak = val;
      CFG_DB:   dead_band = val[7:0];
      CFG_MIN:  min_duty = val[7:0];
      CFG_DFS:  duty_fs = val[7:0];
      CFG_EFS:  enc_fs = val[11:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] p, logic [15:0] i, logic [15:0] dv, logic [15:0] lk,
                           logic [15:0] db, logic [15:0] mn, logic [15:0] dfs,
                           logic [15:0] efs);
    write_reg(CFG_KP, p);
    write_reg(CFG_KI, i);
    write_reg(CFG_KD, dv);
    write_reg(CFG_LEAK, lk);
    write_reg(CFG_DB, db);
    write_reg(CFG_MIN, mn);
    write_reg(CFG_DFS, dfs);
    write_reg(CFG_EFS, efs);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random traffic: mostly edge runs followed by a sample and a control word,
  // with some noise words mixed in.
  task automatic random_traffic(int n);
    int k, run;
    logic b;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 9) == 0) begin
        add_word(2'($urandom_range(0, 3)), 1'($urandom), 10'($urandom), 1'($urandom));
        k++;
      end else begin
        run = $urandom_range(0, 12);
        b = 1'($urandom);
        repeat (run) add_word(OP_EDGE, ($urandom_range(0, 7) == 0) ? !b : b, 10'($urandom),
                              1'b0);
        add_word(OP_SAMPLE, 1'($urandom), 10'($urandom), 1'($urandom));
        add_word(OP_CONTROL, 1'($urandom), 10'($urandom), $urandom_range(0, 5) == 0);
        k += run + 2;
      end
    end
  endtask

  initial begin
    kp = 256; ki = 0; kd = 0; leak = 62259;
    dead_band = 10; min_duty = 60; duty_fs = 255; enc_fs = 100;
    position = '0; last_position = '0;
    speed_now = 0; speed_prev = 0; integral = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at reset defaults: both edge directions, target extremes,
    // integrator clear, and the unused op.
    repeat (30) add_word(OP_EDGE, 1'b0, 10'd0, 1'b0);
    add_word(OP_SAMPLE, 1'b0, 10'd0, 1'b0);
    add_word(OP_CONTROL, 1'b0, 10'h1FF, 1'b0);
    add_word(OP_CONTROL, 1'b1, 10'h200, 1'b1);
    add_word(OP_CONTROL, 1'b0, 10'd0, 1'b0);
    add_word(OP_CONTROL, 1'b0, 10'd100, 1'b1);
    add_word(OP_UNUSED, 1'b1, 10'h3FF, 1'b1);
    repeat (3) add_word(OP_EDGE, 1'b1, 10'd0, 1'b0);
    add_word(OP_SAMPLE, 1'b1, 10'h3FF, 1'b1);
    add_word(OP_CONTROL, 1'b1, 10'h39C, 1'b0);
    wait_drained();

    // Extreme settings: everything at maximum, then at zero (full scales act as one).
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255, 16'd255, 16'd255, 16'd4095);
    random_traffic(50);
    wait_drained();
    write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_traffic(50);
    wait_drained();

    // Random settings with moderate gains, and one fully random set.
    repeat (4) begin
      write_all(16'($urandom_range(0, 2047)), 16'($urandom_range(0, 255)),
                16'($urandom_range(0, 1023)), 16'($urandom), 16'($urandom_range(0, 40)),
                16'($urandom_range(0, 120)), 16'($urandom_range(1, 255)),
                16'($urandom_range(1, 60)));
      random_traffic(55);
      wait_drained();
    end
    write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
              16'($urandom_range(0, 255)), 16'($urandom_range(0, 4095)));
    random_traffic(30);
    wait_drained();

    // Closing stretch without idling on either side.
    idling_on = 1'b0;
    write_all(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 127)),
              16'($urandom_range(0, 511)), 16'($urandom), 16'($urandom_range(0, 30)),
              16'($urandom_range(0, 90)), 16'($urandom_range(1, 255)),
              16'($urandom_range(1, 40)));
    random_traffic(50);
    wait_drained();

    $display("Run covered %0d input words and %0d checked control results", words_sent,
             results_checked);
    $display("over nine register settings, including all-maximum and all-zero extremes.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5ms;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
